// ----- rtl/core/mcstb_pkg.sv -----
// Package for the multi-channel second timer bank.
// Holds the command codes, default sizes and the reset durations.
// No dependencies.
package mcstb_pkg;

  localparam int NUM_TIMERS_DEF = 7;
  localparam int COUNT_BITS_DEF = 16;

  // Duration registers on the configuration port
  localparam int NUM_REGS  = 7;
  localparam int DUR_W     = 16;
  localparam int REG_IDX_W = 3;

  // Fixed field widths
  localparam int OP_W      = 3;
  localparam int TIDX_W    = 3;
  localparam int REM_W     = 16;
  localparam int MASK_W    = 7;
  localparam int FIRST_W   = 3;

  typedef enum logic [OP_W-1:0] {
    OP_TICK      = 3'd0,
    OP_START     = 3'd1,
    OP_START_REC = 3'd2,
    OP_DISARM    = 3'd3,
    OP_QUERY     = 3'd4,
    OP_TAKE      = 3'd5
  } op_e;

  typedef logic [DUR_W-1:0] dur_t;

  localparam dur_t DUR_CONNECT_RETRY = 16'd120;
  localparam dur_t DUR_HOLD          = 16'd30;
  localparam dur_t DUR_KEEPALIVE     = 16'd15;

  // Value of duration register k after reset
  function automatic dur_t dur_reset_val(input int k);
    dur_t v;
    case (k)
      0:       v = DUR_CONNECT_RETRY;
      1:       v = DUR_HOLD;
      2:       v = DUR_KEEPALIVE;
      3:       v = DUR_KEEPALIVE;
      4:       v = DUR_HOLD;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/multi_channel_second_timer_bank_unit.sv -----
// Multi-channel second timer bank: a bank of one-shot/recurring second timers.
// One command per transfer; one result per command.
// Depends on mcstb_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries opcode_i and timer_index_i:
//   tick, start one-shot, start recurring, disarm, query, take fired.
//   Output channel (out_valid_o / out_stall_i) carries one result per command:
//   status, remaining seconds, fired-taken flag, fired mask and lowest fired.
//   The configuration port (cfg_we_i, cfg_index_i, cfg_data_i) writes the
//   duration of timer cfg_index_i; write it only while the bank is idle.
// Timing:
//   A command waits in the input register, is executed against the timer
//   state in a single pass and lands in the result register once that one
//   is empty or not stalled. One command per cycle is sustained while
//   out_stall_i is low; the single-pass update of all counters and flags sets this.
// Reset: all timers disarmed with zero counters, durations at their defaults,
//   both pipeline registers empty.
// Stall: a stalled result holds; the input register takes one more command,
//   then in_stall_o rises until the result is taken.
module multi_channel_second_timer_bank_unit #(
  parameter int NUM_TIMERS = mcstb_pkg::NUM_TIMERS_DEF,
  parameter int COUNT_BITS = mcstb_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [mcstb_pkg::REG_IDX_W-1:0] cfg_index_i,
  input  logic [mcstb_pkg::DUR_W-1:0]     cfg_data_i,
  // command channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [mcstb_pkg::OP_W-1:0]      opcode_i,
  input  logic [mcstb_pkg::TIDX_W-1:0]    timer_index_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            status_o,
  output logic [mcstb_pkg::REM_W-1:0]     remaining_seconds_o,
  output logic                            fired_taken_o,
  output logic [mcstb_pkg::MASK_W-1:0]    fired_mask_o,
  output logic                            any_fired_o,
  output logic [mcstb_pkg::FIRST_W-1:0]   first_fired_o
);
  import mcstb_pkg::*;

  localparam int NDUR = (NUM_TIMERS < NUM_REGS) ? NUM_TIMERS : NUM_REGS;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  // Duration registers
  dur_t dur_q [NDUR];
  dur_t tdur  [NUM_TIMERS];
  cnt_t load  [NUM_TIMERS];

  // Timer state
  cnt_t                  cnt_q [NUM_TIMERS];
  cnt_t                  cnt_d [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] armed_q, armed_d;
  logic [NUM_TIMERS-1:0] rec_q, rec_d;
  logic [NUM_TIMERS-1:0] sel;
  logic [NUM_TIMERS-1:0] fired;

  // Input register
  logic                  in_vld_q, in_vld_d;
  op_e                   op_q;
  logic [TIDX_W-1:0]     idx_q;
  logic                  in_take;
  logic                  advance;
  logic                  idx_ok;

  // Result register
  logic                  out_vld_q, out_vld_d;
  logic                  status_q, status_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic                  taken_q, taken_d;
  logic [MASK_W-1:0]     mask_q, mask_d;
  logic                  any_q, any_d;
  logic [FIRST_W-1:0]    first_q, first_d;

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q  <= op_e'(opcode_i);
      idx_q <= timer_index_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Duration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NDUR; k++) begin
        dur_q[k] <= dur_reset_val(k);
      end
    end else begin
      for (int k = 0; k < NDUR; k++) begin
        if (cfg_we_i && (32'(cfg_index_i) == k)) begin
          dur_q[k] <= cfg_data_i;
        end
      end
    end
  end

  // Timers without a register have zero duration and never arm
  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_dur
    if (g < NDUR) begin : g_reg
      assign tdur[g] = dur_q[g];
    end else begin : g_zero
      assign tdur[g] = '0;
    end
    assign load[g] = COUNT_BITS'(tdur[g]);
  end

  // ---------------------------------------------------------------------------
  // Single-pass command execution
  // ---------------------------------------------------------------------------
  assign idx_ok = 32'(idx_q) < NUM_TIMERS;

  always_comb begin
    for (int k = 0; k < NUM_TIMERS; k++) begin
      sel[k] = idx_ok && (32'(idx_q) == k);
    end
  end

  always_comb begin
    status_d = 1'b0;
    rem_d    = '0;
    taken_d  = 1'b0;
    armed_d  = armed_q;
    rec_d    = rec_q;
    for (int k = 0; k < NUM_TIMERS; k++) begin
      cnt_d[k] = cnt_q[k];
    end

    case (op_q)
      OP_START, OP_START_REC, OP_DISARM, OP_QUERY, OP_TAKE: status_d = !idx_ok;
      default:                                              status_d = 1'b0;
    endcase

    for (int k = 0; k < NUM_TIMERS; k++) begin
      case (op_q)
        OP_TICK: begin
          if (armed_q[k] && (cnt_q[k] != '0)) begin
            cnt_d[k] = cnt_q[k] - 1'b1;
          end
        end
        OP_START, OP_START_REC: begin
          if (sel[k]) begin
            // zero duration: disarm, leave counter and mode alone
            if (tdur[k] == '0) begin
              armed_d[k] = 1'b0;
            end else begin
              cnt_d[k]   = load[k];
              armed_d[k] = 1'b1;
              rec_d[k]   = (op_q == OP_START_REC);
            end
          end
        end
        OP_DISARM: begin
          if (sel[k]) begin
            armed_d[k] = 1'b0;
            rec_d[k]   = 1'b0;
            cnt_d[k]   = '0;
          end
        end
        OP_QUERY: begin
          if (sel[k] && armed_q[k]) begin
            rem_d = rem_d | REM_W'(cnt_q[k]);
          end
        end
        OP_TAKE: begin
          if (sel[k] && armed_q[k] && (cnt_q[k] == '0)) begin
            taken_d = 1'b1;
            if (rec_q[k]) begin
              cnt_d[k] = load[k];
            end else begin
              armed_d[k] = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end

    // fired view after the step
    for (int k = 0; k < NUM_TIMERS; k++) begin
      fired[k] = armed_d[k] && (cnt_d[k] == '0);
    end
    any_d   = |fired;
    first_d = '0;
    for (int k = NUM_TIMERS - 1; k >= 0; k--) begin
      if (fired[k]) begin
        first_d = FIRST_W'(k);
      end
    end
    for (int j = 0; j < MASK_W; j++) begin
      mask_d[j] = (j < NUM_TIMERS) ? fired[j % NUM_TIMERS] : 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= '0;
      rec_q   <= '0;
      for (int k = 0; k < NUM_TIMERS; k++) begin
        cnt_q[k] <= '0;
      end
    end else if (advance) begin
      armed_q <= armed_d;
      rec_q   <= rec_d;
      for (int k = 0; k < NUM_TIMERS; k++) begin
        cnt_q[k] <= cnt_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q <= status_d;
      rem_q    <= rem_d;
      taken_q  <= taken_d;
      mask_q   <= mask_d;
      any_q    <= any_d;
      first_q  <= first_d;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign status_o            = status_q;
  assign remaining_seconds_o = rem_q;
  assign fired_taken_o       = taken_q;
  assign fired_mask_o        = mask_q;
  assign any_fired_o         = any_q;
  assign first_fired_o       = first_q;

endmodule

// ----- dv/timer_bank_checker.sv -----
`timescale 1ns / 1ps
// Checker for the multi-channel second timer bank: keeps its own copy of the durations
// and timer state, predicts each result and compares it field by field.
// Depends on mcstb_pkg.
module timer_bank_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mcstb_pkg::REG_IDX_W-1:0] cfg_index_i,
  input  logic [mcstb_pkg::DUR_W-1:0]     cfg_data_i,
  input  logic                            cmd_valid_i,
  input  logic                            cmd_stall_i,
  input  logic [mcstb_pkg::OP_W-1:0]      opcode_i,
  input  logic [mcstb_pkg::TIDX_W-1:0]    timer_index_i,
  input  logic                            res_valid_i,
  input  logic                            res_stall_i,
  input  logic                            status_i,
  input  logic [mcstb_pkg::REM_W-1:0]     remaining_seconds_i,
  input  logic                            fired_taken_i,
  input  logic [mcstb_pkg::MASK_W-1:0]    fired_mask_i,
  input  logic                            any_fired_i,
  input  logic [mcstb_pkg::FIRST_W-1:0]   first_fired_i,
  output int                              pending_o,
  output int                              checked_o,
  output int                              fail_count_o
);
  import mcstb_pkg::*;

  localparam int TIMERS = NUM_TIMERS_DEF;

  typedef struct packed {
    logic               status;
    logic [REM_W-1:0]   remaining;
    logic               taken;
    logic [MASK_W-1:0]  mask;
    logic               any;
    logic [FIRST_W-1:0] first;
  } bank_result_t;

  logic [DUR_W-1:0]          duration_q [TIMERS];
  logic [COUNT_BITS_DEF-1:0] count_q    [TIMERS];
  logic                      armed_q    [TIMERS];
  logic                      recur_q    [TIMERS];
  bank_result_t              expected_results [$];
  int                        fail_cnt    = 0;
  int                        checked_cnt = 0;

  assign fail_count_o = fail_cnt;
  assign checked_o    = checked_cnt;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_cnt++;
    $display("%0t: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
  endtask

  task automatic load_timer(input int k, input logic recurring);
    // a zero duration only disarms
    if (duration_q[k] == '0) begin
      armed_q[k] = 1'b0;
    end else begin
      count_q[k] = duration_q[k];
      armed_q[k] = 1'b1;
      recur_q[k] = recurring;
    end
  endtask

  task automatic predict_bank_result(input logic [OP_W-1:0] op, input logic [TIDX_W-1:0] idx,
                                     output bank_result_t res);
    int k;
    res = '0;
    if (op == OP_TICK) begin
      for (k = 0; k < TIMERS; k++) begin
        if (armed_q[k] && count_q[k] != '0) count_q[k] = count_q[k] - 1'b1;
      end
    end else if (op <= OP_TAKE) begin
      if (idx >= TIMERS) begin
        res.status = 1'b1;
      end else begin
        case (op)
          OP_START:     load_timer(idx, 1'b0);
          OP_START_REC: load_timer(idx, 1'b1);
          OP_DISARM: begin
            armed_q[idx] = 1'b0;
            recur_q[idx] = 1'b0;
            count_q[idx] = '0;
          end
          OP_QUERY: res.remaining = armed_q[idx] ? count_q[idx] : '0;
          default: begin
            if (armed_q[idx] && count_q[idx] == '0) begin
              res.taken = 1'b1;
              if (recur_q[idx]) count_q[idx] = duration_q[idx];
              else armed_q[idx] = 1'b0;
            end
          end
        endcase
      end
    end
    // walk down so the lowest fired timer is the one left in first
    for (k = TIMERS - 1; k >= 0; k--) begin
      if (armed_q[k] && count_q[k] == '0) begin
        res.mask[k] = 1'b1;
        res.any     = 1'b1;
        res.first   = k[FIRST_W-1:0];
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bank_result_t res;
    bank_result_t want;
    int k;
    if (!rst_ni) begin
      duration_q[0] = 16'd120;
      duration_q[1] = 16'd30;
      duration_q[2] = 16'd15;
      duration_q[3] = 16'd15;
      duration_q[4] = 16'd30;
      duration_q[5] = 16'd0;
      duration_q[6] = 16'd0;
      for (k = 0; k < TIMERS; k++) begin
        count_q[k] = '0;
        armed_q[k] = 1'b0;
        recur_q[k] = 1'b0;
      end
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i && cfg_index_i < NUM_REGS) duration_q[cfg_index_i] = cfg_data_i;
      if (cmd_valid_i && !cmd_stall_i) begin
        predict_bank_result(opcode_i, timer_index_i, res);
        expected_results.push_back(res);
      end
      if (res_valid_i && !res_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, fired_mask", fired_mask_i, 0);
        end else begin
          want = expected_results.pop_front();
          checked_cnt++;
          if (status_i !== want.status) report_mismatch("status", status_i, want.status);
          if (remaining_seconds_i !== want.remaining)
            report_mismatch("remaining_seconds", remaining_seconds_i, want.remaining);
          if (fired_taken_i !== want.taken)
            report_mismatch("fired_taken", fired_taken_i, want.taken);
          if (fired_mask_i !== want.mask)
            report_mismatch("fired_mask", fired_mask_i, want.mask);
          if (any_fired_i !== want.any) report_mismatch("any_fired", any_fired_i, want.any);
          if (first_fired_i !== want.first)
            report_mismatch("first_fired", first_fired_i, want.first);
        end
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Top of the timer bank testbench: clock, reset, duration writes, command stimulus
// and result-side stalls; the checker beside the block gives the failure count.
// Depends on mcstb_pkg, multi_channel_second_timer_bank_unit and timer_bank_checker.
module testbench;
  import mcstb_pkg::*;

  localparam int NUM_SETTINGS      = 10;
  localparam int ITEMS_PER_SETTING = 173;
  localparam int HOLD_OFF_CYCLES   = 300;
  localparam int QUIET_LIMIT       = 5000;
  localparam int DRAIN_CYCLES      = 8;

  localparam logic [OP_W-1:0]   OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0]   OP_SPARE_B = 3'd7;
  localparam logic [TIDX_W-1:0] BAD_TIMER  = 3'd7;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CONNECT_RETRY,
    REG_HOLD,
    REG_KEEPALIVE,
    REG_ORIGIN_INTERVAL,
    REG_ADVERT_INTERVAL,
    REG_DELAY_OPEN,
    REG_IDLE_HOLD
  } dur_reg_e;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [DUR_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [OP_W-1:0]      opcode;
  logic [TIDX_W-1:0]    timer_index;
  logic                 out_valid;
  logic                 out_stall;
  logic                 status;
  logic [REM_W-1:0]     remaining_seconds;
  logic                 fired_taken;
  logic [MASK_W-1:0]    fired_mask;
  logic                 any_fired;
  logic [FIRST_W-1:0]   first_fired;

  int pending;
  int checked;
  int fail_count;

  logic             hold_req = 1'b0;
  int               send_pct = 0;
  int               recv_pct = 0;
  int               cmd_sent = 0;
  logic [DUR_W-1:0] next_dur [NUM_REGS];

  always #1 clk = ~clk;

  multi_channel_second_timer_bank_unit dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .opcode_i            (opcode),
    .timer_index_i       (timer_index),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .status_o            (status),
    .remaining_seconds_o (remaining_seconds),
    .fired_taken_o       (fired_taken),
    .fired_mask_o        (fired_mask),
    .any_fired_o         (any_fired),
    .first_fired_o       (first_fired)
  );

  timer_bank_checker checker_i (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .cmd_valid_i         (in_valid),
    .cmd_stall_i         (in_stall),
    .opcode_i            (opcode),
    .timer_index_i       (timer_index),
    .res_valid_i         (out_valid),
    .res_stall_i         (out_stall),
    .status_i            (status),
    .remaining_seconds_i (remaining_seconds),
    .fired_taken_i       (fired_taken),
    .fired_mask_i        (fired_mask),
    .any_fired_i         (any_fired),
    .first_fired_i       (first_fired),
    .pending_o           (pending),
    .checked_o           (checked),
    .fail_count_o        (fail_count)
  );

  // Result side: random stalls, or one long hold-off on request
  initial begin : result_sink
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [TIDX_W-1:0] idx);
    while (send_pct > 0 && $urandom_range(99) < send_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    opcode      <= op;
    timer_index <= idx;
    // hold the command until the transfer
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cmd_sent++;
  endtask

  task automatic wait_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  task automatic load_durations();
    int k;
    wait_results();
    for (k = 0; k < NUM_REGS; k++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= k[REG_IDX_W-1:0];
      cfg_data  <= next_dur[k];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int               s;
    int               n;
    int               r;
    int               k;
    logic [OP_W-1:0]   op;
    logic [TIDX_W-1:0] idx;

    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    opcode      = OP_TICK;
    timer_index = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Reset durations: idle query, starts, zero-duration starts, bad index, spare codes
    send_cmd(OP_QUERY, 3'd0);
    send_cmd(OP_START, 3'd0);
    send_cmd(OP_START_REC, 3'd1);
    send_cmd(OP_QUERY, 3'd0);
    send_cmd(OP_START, 3'd5);
    send_cmd(OP_START_REC, 3'd6);
    send_cmd(OP_START, BAD_TIMER);
    send_cmd(OP_TAKE, BAD_TIMER);
    send_cmd(OP_DISARM, BAD_TIMER);
    send_cmd(OP_SPARE_A, 3'd3);
    send_cmd(OP_SPARE_B, BAD_TIMER);
    send_cmd(OP_TICK, BAD_TIMER);
    send_cmd(OP_TAKE, 3'd0);
    send_cmd(OP_DISARM, 3'd0);
    send_cmd(OP_QUERY, 3'd0);

    // Short durations: fire, take one-shot and recurring, full-scale count
    next_dur[REG_CONNECT_RETRY]   = '1;
    next_dur[REG_HOLD]            = 16'd1;
    next_dur[REG_KEEPALIVE]       = 16'd1;
    next_dur[REG_ORIGIN_INTERVAL] = '0;
    next_dur[REG_ADVERT_INTERVAL] = 16'd1;
    next_dur[REG_DELAY_OPEN]      = '1;
    next_dur[REG_IDLE_HOLD]       = 16'd2;
    load_durations();
    send_cmd(OP_START, 3'd0);
    send_cmd(OP_QUERY, 3'd0);
    send_cmd(OP_START, 3'd1);
    send_cmd(OP_START_REC, 3'd2);
    send_cmd(OP_START_REC, 3'd4);
    send_cmd(OP_TICK, 3'd0);
    send_cmd(OP_TAKE, 3'd1);
    send_cmd(OP_TAKE, 3'd2);
    send_cmd(OP_TAKE, 3'd1);

    // Recurring timer whose duration dropped to zero reloads to zero and stays fired
    next_dur[REG_ADVERT_INTERVAL] = '0;
    load_durations();
    send_cmd(OP_TAKE, 3'd4);
    send_cmd(OP_TAKE, 3'd4);
    send_cmd(OP_START, 3'd4);

    for (s = 0; s < NUM_SETTINGS; s++) begin
      for (k = 0; k < NUM_REGS; k++) begin
        r = $urandom_range(99);
        if (s == 1) next_dur[k] = '1;
        else if (s == 4) next_dur[k] = '0;
        else if (r < 8) next_dur[k] = '0;
        else if (r < 14) next_dur[k] = '1;
        else if (r < 22) next_dur[k] = DUR_W'($urandom);
        else next_dur[k] = DUR_W'($urandom_range(5, 1));
      end
      load_durations();
      if (s < 4) begin
        send_pct = 38;
        recv_pct = 49;
      end else if (s < 7) begin
        send_pct = 49;
        recv_pct = 38;
      end else begin
        send_pct = 0;
        recv_pct = 0;
      end
      for (n = 0; n < ITEMS_PER_SETTING; n++) begin
        if (s == 2 && n == 60) hold_req = 1'b1;
        r = $urandom_range(99);
        if (r < 40) op = OP_TICK;
        else if (r < 55) op = OP_START;
        else if (r < 67) op = OP_START_REC;
        else if (r < 73) op = OP_DISARM;
        else if (r < 85) op = OP_QUERY;
        else if (r < 97) op = OP_TAKE;
        else op = (r < 99) ? OP_SPARE_A : OP_SPARE_B;
        idx = ($urandom_range(99) < 6) ? BAD_TIMER : TIDX_W'($urandom_range(6, 0));
        send_cmd(op, idx);
      end
    end

    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Summary: %0d commands sent, %0d results compared, %0d duration settings",
             cmd_sent, checked, NUM_SETTINGS + 3);
    $display("Summary: stalls on both sides, one long result hold-off, %0d mismatches",
             fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
